>>> hw/rtl/suffix_automaton_next_value_lookup_top_assert.svh
// assertion macros for the suffix automaton lookup block
`ifndef SUFFIX_AUTOMATON_NEXT_VALUE_LOOKUP_TOP_ASSERT_SVH
`define SUFFIX_AUTOMATON_NEXT_VALUE_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SANVL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sanvl assertion failed");
`define SANVL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sanvl implication failed");
`else
`define SANVL_ASSERT(lbl, clk, rst, prop)
`define SANVL_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/sanvl_pkg.sv
// shared constants for the suffix automaton lookup block
`default_nettype none
package sanvl_pkg;
   localparam int DEF_MAX_TOKENS = 1024;
   localparam int TOKEN_W        = 8;
   localparam int VALUE_W        = 16;
   localparam int CSR_IDX_W      = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT = CSR_IDX_W'(1);
   localparam logic [VALUE_W-1:0]   DEFAULT_RESET = '1;
endpackage
`default_nettype wire

>>> hw/rtl/suffix_automaton_next_value_lookup_top.sv
// online suffix automaton with longest-suffix value lookup
// each item clears the transition row of its new state, one entry per cycle, then walks the
//   suffix links; the first item after a clear also clears the root row, a clone copies
//   a row, and a full store answers with overflow and the default value
// one item at a time, req_ready returns in the same cycle as rsp_valid; reset: synchronous,
//   empties the automaton, mode 0, default value -1; memories not cleared
`default_nettype none
module suffix_automaton_next_value_lookup_top
   import sanvl_pkg::*;
#(
   parameter int MAX_TOKENS = DEF_MAX_TOKENS,
   localparam int POS_W = $clog2(MAX_TOKENS)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_start_req,
   input  wire logic [TOKEN_W-1:0]        req_key_token,
   input  wire logic [TOKEN_W-1:0]        req_query_token,
   input  wire logic signed [VALUE_W-1:0] req_value_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_result_value,
   output logic                           rsp_found,
   output logic [POS_W-1:0]               rsp_match_position,
   output logic                           rsp_overflow,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [VALUE_W-1:0]        csr_data
);
   // state ids, counts and lengths
   localparam int SB   = $clog2(2 * MAX_TOKENS);
   localparam int SCW  = $clog2(2 * MAX_TOKENS + 1);
   localparam int TCW  = $clog2(MAX_TOKENS + 1);
   localparam int LW   = TCW;
   localparam int TTA  = SB + TOKEN_W;
   localparam int NST  = 2 * MAX_TOKENS;
   localparam int TTD  = NST * (2 ** TOKEN_W);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_ROOT, S_CLR, S_APPEND, S_NEWR, S_L1_RD, S_L1_CHK,
      S_H_RD1, S_H_RD2, S_H_CHK, S_LINK_C, S_LINK_R, S_CP, S_CP_TAIL,
      S_L2_RD, S_L2_CHK, S_AFTER, S_Q_RD, S_Q_CHK, S_W_RD, S_W_CHK,
      S_U_RD, S_U_CHK, S_V_RD, S_V_GET, S_DONE
   } state_type;

   state_type state_ff;

   // automaton memories, one synchronous read port each
   logic [SB-1:0]      tt_mem   [TTD];
   logic [LW-1:0]      len_mem  [NST];
   logic [SB-1:0]      link_mem [NST];
   logic [POS_W-1:0]   end_mem  [NST];
   logic               has_mem  [NST];
   logic [VALUE_W-1:0] vs_mem   [MAX_TOKENS];

   logic [SB-1:0]      rd_tt_ff, rd_link_ff;
   logic [LW-1:0]      rd_len_ff;
   logic [POS_W-1:0]   rd_end_ff;
   logic               rd_has_ff;
   logic [VALUE_W-1:0] rd_vs_ff;

   // control registers
   logic               mode_ff;
   logic [VALUE_W-1:0] dflt_ff;
   logic [SCW-1:0]     sc_ff;
   logic [TCW-1:0]     tc_ff;
   logic [SB-1:0]      lk_ff, lq_ff;
   logic [SB-1:0]      r_ff, p_ff, c_ff, u_ff, walk_ff, row_ff;
   logic [LW-1:0]      lenp_ff;
   logic [TOKEN_W-1:0] sw_ff, cp_sym_ff;
   logic               cp_pend_ff, clr_root_ff;
   logic               hit_ff, ovf_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [VALUE_W-1:0] res_ff;
   logic               rsp_valid_ff;

   // item payload
   logic [TOKEN_W-1:0] key_ff, query_ff;
   logic [VALUE_W-1:0] value_ff;

   // memory port controls
   logic [TTA-1:0]     tt_raddr, tt_waddr;
   logic [SB-1:0]      tt_wdata;
   logic               tt_we;
   logic [SB-1:0]      st_raddr;
   logic [SB-1:0]      len_waddr, link_waddr, end_waddr;
   logic [LW-1:0]      len_wdata;
   logic [SB-1:0]      link_wdata;
   logic [POS_W-1:0]   end_wdata;
   logic               has_wdata;
   logic               len_we, link_we, end_we;
   logic [POS_W-1:0]   vs_raddr;
   logic               vs_we;

   logic [TOKEN_W-1:0] qtok;
   logic [POS_W-1:0]   cur_pos;
   logic [POS_W-1:0]   pos_next;
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign qtok      = mode_ff ? query_ff : key_ff;
   // position of the item being appended
   assign cur_pos   = POS_W'(tc_ff - TCW'(1));
   // sequence mode reads the value after the match, wrapping at the store end
   assign pos_next  = (pos_ff == POS_W'(MAX_TOKENS - 1)) ? '0 : POS_W'(pos_ff + POS_W'(1));

   // read addresses and write strobes by sequencer step
   always_comb begin
      tt_raddr   = {p_ff, key_ff};
      tt_waddr   = {p_ff, key_ff};
      tt_wdata   = r_ff;
      tt_we      = 1'b0;
      st_raddr   = walk_ff;
      len_waddr  = r_ff;
      len_wdata  = '0;
      len_we     = 1'b0;
      link_waddr = r_ff;
      link_wdata = '0;
      link_we    = 1'b0;
      end_waddr  = r_ff;
      end_wdata  = '0;
      has_wdata  = 1'b0;
      end_we     = 1'b0;
      vs_raddr   = mode_ff ? pos_ff : pos_next;
      vs_we      = 1'b0;
      case (state_ff)
         S_ROOT: begin
            len_waddr  = '0;
            link_waddr = '0;
            end_waddr  = '0;
            len_we     = 1'b1;
            link_we    = 1'b1;
            end_we     = 1'b1;
         end
         S_CLR: begin
            tt_waddr = {row_ff, sw_ff};
            tt_wdata = '0;
            tt_we    = 1'b1;
         end
         S_APPEND: begin
            st_raddr = lk_ff;
            vs_we    = 1'b1;
         end
         S_NEWR: begin
            len_wdata = LW'(rd_len_ff + LW'(1));
            len_we    = 1'b1;
            link_we   = 1'b1;
            end_we    = 1'b1;
         end
         S_L1_RD, S_L2_RD: st_raddr = p_ff;
         S_L1_CHK: tt_we = (rd_tt_ff == '0);
         S_H_RD1: st_raddr = p_ff;
         S_H_RD2: st_raddr = c_ff;
         S_H_CHK: begin
            if (LW'(lenp_ff + LW'(1)) == rd_len_ff) begin
               link_wdata = c_ff;
               link_we    = 1'b1;
            end else begin
               len_waddr  = sc_ff[SB-1:0];
               len_wdata  = LW'(lenp_ff + LW'(1));
               len_we     = 1'b1;
               link_waddr = sc_ff[SB-1:0];
               link_wdata = rd_link_ff;
               link_we    = 1'b1;
               end_waddr  = sc_ff[SB-1:0];
               end_wdata  = rd_end_ff;
               has_wdata  = rd_has_ff;
               end_we     = 1'b1;
            end
         end
         S_LINK_C: begin
            link_waddr = c_ff;
            link_wdata = u_ff;
            link_we    = 1'b1;
         end
         S_LINK_R: begin
            link_wdata = u_ff;
            link_we    = 1'b1;
         end
         S_CP: tt_raddr = {c_ff, sw_ff};
         S_L2_CHK: begin
            tt_wdata = u_ff;
            tt_we    = (rd_tt_ff == c_ff);
         end
         S_Q_RD: tt_raddr = {walk_ff, qtok};
         S_U_CHK: begin
            end_waddr = walk_ff;
            end_wdata = cur_pos;
            has_wdata = 1'b1;
            end_we    = !(rd_has_ff && rd_end_ff >= cur_pos);
         end
         default: ;
      endcase
      // pending half of the row copy pipe
      if (cp_pend_ff) begin
         tt_waddr = {u_ff, cp_sym_ff};
         tt_wdata = rd_tt_ff;
         tt_we    = 1'b1;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
      rd_tt_ff <= tt_mem[tt_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_waddr] <= len_wdata;
      rd_len_ff <= len_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      rd_link_ff <= link_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[end_waddr] <= end_wdata;
         has_mem[end_waddr] <= has_wdata;
      end
      rd_end_ff <= end_mem[st_raddr];
      rd_has_ff <= has_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (vs_we) vs_mem[tc_ff[POS_W-1:0]] <= value_ff;
      rd_vs_ff <= vs_mem[vs_raddr];
   end

   // sequencer, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         dflt_ff      <= DEFAULT_RESET;
         sc_ff        <= '0;
         tc_ff        <= '0;
         lk_ff        <= '0;
         lq_ff        <= '0;
         cp_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cp_pend_ff <= (state_ff == S_CP);
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MODE:    mode_ff <= csr_data[0];
               CSR_DEFAULT: dflt_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  key_ff   <= req_key_token;
                  query_ff <= req_query_token;
                  value_ff <= req_value_in;
                  hit_ff   <= 1'b0;
                  ovf_ff   <= 1'b0;
                  pos_ff   <= '0;
                  if (req_start_req) begin
                     sc_ff <= '0;
                     tc_ff <= '0;
                     lk_ff <= '0;
                     lq_ff <= '0;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (tc_ff == TCW'(MAX_TOKENS)) begin
                  ovf_ff   <= 1'b1;
                  res_ff   <= dflt_ff;
                  state_ff <= S_DONE;
               end else if (sc_ff == '0) begin
                  state_ff <= S_ROOT;
               end else begin
                  state_ff <= S_APPEND;
               end
            end
            S_ROOT: begin
               sc_ff       <= SCW'(1);
               row_ff      <= '0;
               sw_ff       <= '0;
               clr_root_ff <= 1'b1;
               state_ff    <= S_CLR;
            end
            S_CLR: begin
               sw_ff <= sw_ff + TOKEN_W'(1);
               if (sw_ff == '1) state_ff <= clr_root_ff ? S_APPEND : S_L1_RD;
            end
            S_APPEND: begin
               tc_ff    <= tc_ff + TCW'(1);
               r_ff     <= sc_ff[SB-1:0];
               sc_ff    <= sc_ff + SCW'(1);
               p_ff     <= lk_ff;
               state_ff <= S_NEWR;
            end
            S_NEWR: begin
               row_ff      <= r_ff;
               sw_ff       <= '0;
               clr_root_ff <= 1'b0;
               state_ff    <= S_CLR;
            end
            S_L1_RD: state_ff <= S_L1_CHK;
            S_L1_CHK: begin
               if (rd_tt_ff != '0) begin
                  c_ff     <= rd_tt_ff;
                  state_ff <= S_H_RD1;
               end else if (p_ff == '0) begin
                  state_ff <= S_AFTER;
               end else begin
                  p_ff     <= rd_link_ff;
                  state_ff <= S_L1_RD;
               end
            end
            S_H_RD1: state_ff <= S_H_RD2;
            S_H_RD2: begin
               lenp_ff  <= rd_len_ff;
               state_ff <= S_H_CHK;
            end
            S_H_CHK: begin
               if (LW'(lenp_ff + LW'(1)) == rd_len_ff) begin
                  state_ff <= S_AFTER;
               end else begin
                  u_ff     <= sc_ff[SB-1:0];
                  sc_ff    <= sc_ff + SCW'(1);
                  state_ff <= S_LINK_C;
               end
            end
            S_LINK_C: state_ff <= S_LINK_R;
            S_LINK_R: begin
               sw_ff    <= '0;
               state_ff <= S_CP;
            end
            S_CP: begin
               cp_sym_ff <= sw_ff;
               sw_ff     <= sw_ff + TOKEN_W'(1);
               if (sw_ff == '1) state_ff <= S_CP_TAIL;
            end
            S_CP_TAIL: state_ff <= S_L2_RD;
            S_L2_RD: state_ff <= S_L2_CHK;
            S_L2_CHK: begin
               if (rd_tt_ff != c_ff || p_ff == '0) begin
                  state_ff <= S_AFTER;
               end else begin
                  p_ff     <= rd_link_ff;
                  state_ff <= S_L2_RD;
               end
            end
            S_AFTER: begin
               lk_ff <= r_ff;
               if (!mode_ff) begin
                  walk_ff  <= lq_ff;
                  state_ff <= S_Q_RD;
               end else begin
                  walk_ff  <= r_ff;
                  state_ff <= S_U_RD;
               end
            end
            S_Q_RD: state_ff <= S_Q_CHK;
            S_Q_CHK: begin
               if (rd_tt_ff != '0) begin
                  walk_ff  <= rd_tt_ff;
                  lq_ff    <= rd_tt_ff;
                  state_ff <= S_W_RD;
               end else if (walk_ff == '0) begin
                  lq_ff <= '0;
                  if (!mode_ff) begin
                     walk_ff  <= r_ff;
                     state_ff <= S_U_RD;
                  end else begin
                     state_ff <= S_V_RD;
                  end
               end else begin
                  walk_ff  <= rd_link_ff;
                  state_ff <= S_Q_RD;
               end
            end
            S_W_RD: state_ff <= S_W_CHK;
            S_W_CHK: begin
               if ((rd_len_ff != '0 && rd_has_ff) || walk_ff == '0) begin
                  if (rd_len_ff != '0 && rd_has_ff) begin
                     hit_ff <= 1'b1;
                     pos_ff <= rd_end_ff;
                  end
                  if (!mode_ff) begin
                     walk_ff  <= r_ff;
                     state_ff <= S_U_RD;
                  end else begin
                     state_ff <= S_V_RD;
                  end
               end else begin
                  walk_ff  <= rd_link_ff;
                  state_ff <= S_W_RD;
               end
            end
            S_U_RD: state_ff <= S_U_CHK;
            S_U_CHK: begin
               if ((rd_has_ff && rd_end_ff >= cur_pos) || walk_ff == '0) begin
                  if (!mode_ff) begin
                     state_ff <= S_V_RD;
                  end else begin
                     walk_ff  <= lq_ff;
                     state_ff <= S_Q_RD;
                  end
               end else begin
                  walk_ff  <= rd_link_ff;
                  state_ff <= S_U_RD;
               end
            end
            S_V_RD: state_ff <= S_V_GET;
            S_V_GET: begin
               res_ff   <= hit_ff ? rd_vs_ff : dflt_ff;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_result_value   <= res_ff;
                  rsp_found          <= hit_ff;
                  rsp_match_position <= pos_ff;
                  rsp_overflow       <= ovf_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "suffix_automaton_next_value_lookup_top_assert.svh"

   `SANVL_ASSERT(a_sc_bound, clock, reset, sc_ff <= SCW'(NST))
   `SANVL_ASSERT(a_tc_bound, clock, reset, tc_ff <= TCW'(MAX_TOKENS))
   `SANVL_ASSERT_IMPLY(a_ovf_nohit, clock, reset, rsp_valid && rsp_overflow, !rsp_found)
   `SANVL_ASSERT_IMPLY(a_cp_pipe, clock, reset, cp_pend_ff,
                       state_ff == S_CP || state_ff == S_CP_TAIL)
   `SANVL_ASSERT(a_one_item, clock, reset, accept |=> !req_ready)

endmodule
`default_nettype wire
